FILE: rtl/core/lsfe_pkg.sv
package lsfe_pkg;

   // slot pool
   localparam int SLOT_COUNT = 40;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = 6;

   localparam logic [7:0] FADE_STEP = 8'd5;
   localparam logic [7:0] LEVEL_TOP = 8'd255;

   // x/5 == (x*205)>>10 for every 8-bit x
   localparam logic [7:0] DIV5_MUL   = 8'd205;
   localparam int         DIV5_SHIFT = 10;

   typedef enum logic [1:0] {
      CSR_SPAWN_INTERVAL  = 2'd0,
      CSR_UPDATE_INTERVAL = 2'd1,
      CSR_ACTIVE_LIMIT    = 2'd2
   } csr_index_type;

   localparam logic KIND_CLEAR = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic [7:0] led;
      logic [7:0] level;
      logic       falling;
   } slot_entry_type;

   typedef struct packed {
      logic [7:0] level;
      logic       falling;
      logic [5:0] green;
      logic       freed;
   } fade_result_type;

endpackage

FILE: rtl/core/lsfe_slot_ram.sv
module lsfe_slot_ram (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [lsfe_pkg::SLOT_IDX_W-1:0] wr_addr,
   input  lsfe_pkg::slot_entry_type        wr_data,
   input  logic                            rd_en,
   input  logic [lsfe_pkg::SLOT_IDX_W-1:0] rd_addr,
   output lsfe_pkg::slot_entry_type        rd_data
);
   import lsfe_pkg::*;

   slot_entry_type mem_ff [SLOT_COUNT];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lsfe_fade_unit.sv
module lsfe_fade_unit (
   input  lsfe_pkg::slot_entry_type  base,
   output lsfe_pkg::fade_result_type result
);
   import lsfe_pkg::*;

   logic [8:0]  up_sum;
   logic [7:0]  lv;
   logic        fall;
   logic [15:0] prod;

   always_comb begin
      up_sum = {1'b0, base.level} + {1'b0, FADE_STEP};
      if (base.falling) begin
         lv   = (base.level > FADE_STEP) ? (base.level - FADE_STEP) : 8'd0;
         fall = 1'b1;
      end else if (up_sum >= {1'b0, LEVEL_TOP}) begin
         lv   = LEVEL_TOP;
         fall = 1'b1;
      end else begin
         lv   = up_sum[7:0];
         fall = 1'b0;
      end
      prod = {8'd0, lv} * {8'd0, DIV5_MUL};
      result.level   = lv;
      result.falling = fall;
      result.green   = prod[DIV5_SHIFT +: 6];
      result.freed   = (lv == 8'd0);
   end

endmodule

FILE: rtl/core/led_sparkle_fade_engine.sv
// Sparkle fade engine. Each accepted req word (time stamp, random strip
// position) may start one fade slot and, when the update interval has been
// exceeded, produces a frame: one clear word, then one pixel word per slot
// still lit, last set on the final word. An item with nothing due goes
// through accept and evaluate only. An item that starts a slot or updates
// goes through accept, evaluate, a walk of the slot memory at one slot per
// cycle (unless rsp_stall holds the modify stage) through its single read
// port, with a read stage and a modify stage, and a flush of the held-back
// final word. A new slot is placed in the walk at the first free slot, so,
// when the item also updates, it is faded in the same frame. req_stall is
// high from accept until the item is done; for a frame, until its last word
// sits in the rsp register.
module led_sparkle_fade_engine (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_random_led,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_led_index,
   output logic [7:0]  rsp_red,
   output logic [5:0]  rsp_green,
   output logic        rsp_last,
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import lsfe_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_WALK,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [15:0]      spawn_int_ff, spawn_int_in;
   logic [15:0]      upd_int_ff, upd_int_in;
   logic [CNT_W-1:0] limit_ff, limit_in;

   // captured item
   logic [31:0] now_ff, now_in;
   logic [7:0]  rnd_ff, rnd_in;

   // engine state
   logic [SLOT_COUNT-1:0] active_ff, active_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [31:0]           last_spawn_ff, last_spawn_in;
   logic [31:0]           last_update_ff, last_update_in;
   logic                  spawn_ff, spawn_in;   // start still to be placed
   logic                  upd_ff, upd_in;       // this item updates

   // walk pipeline: read stage index, modify stage
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             mod_valid_ff, mod_valid_in;
   logic [CNT_W-1:0] mod_idx_ff, mod_idx_in;

   // held-back word, so last can be set on the final one
   logic       pend_valid_ff, pend_valid_in;
   logic       pend_kind_ff, pend_kind_in;
   logic [7:0] pend_led_ff, pend_led_in;
   logic [7:0] pend_red_ff, pend_red_in;
   logic [5:0] pend_green_ff, pend_green_in;

   // rsp register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_led_ff, rsp_led_in;
   logic [7:0] rsp_red_ff, rsp_red_in;
   logic [5:0] rsp_green_ff, rsp_green_in;
   logic       rsp_last_ff, rsp_last_in;

   // slot memory ports
   logic                  ram_wr_en;
   logic [SLOT_IDX_W-1:0] ram_wr_addr;
   slot_entry_type        ram_wr_data;
   logic                  ram_rd_en;
   logic [SLOT_IDX_W-1:0] ram_rd_addr;
   slot_entry_type        ram_rd_data;

   slot_entry_type  base;
   fade_result_type fres;

   logic [31:0]           spawn_age;
   logic [31:0]           update_age;
   logic [SLOT_IDX_W-1:0] mod_i;
   logic                  slot_act;
   logic                  spawn_here;
   logic                  live;
   logic                  emit;
   logic                  out_free;
   logic                  mod_stall;
   logic                  walk_busy;

   lsfe_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lsfe_fade_unit u_fade (
      .base   (base),
      .result (fres)
   );

   // modify stage: slot read last cycle, or the new slot placed here
   always_comb begin
      spawn_age  = now_ff - last_spawn_ff;
      update_age = now_ff - last_update_ff;
      mod_i      = mod_idx_ff[SLOT_IDX_W-1:0];
      slot_act   = active_ff[mod_i];
      spawn_here = spawn_ff && !slot_act;
      live       = slot_act || spawn_here;
      if (spawn_here) begin
         base.led     = rnd_ff;
         base.level   = 8'd0;
         base.falling = 1'b0;
      end else begin
         base = ram_rd_data;
      end
      walk_busy = (state_ff == ST_WALK) && mod_valid_ff;
      emit      = walk_busy && upd_ff && live && !fres.freed;
      out_free  = !rsp_valid_ff || !rsp_stall;
      // pixel ready but both words ahead of it still full
      mod_stall = emit && pend_valid_ff && !out_free;
   end

   // memory access
   always_comb begin
      ram_wr_en   = walk_busy && live && !mod_stall;
      ram_wr_addr = mod_i;
      if (upd_ff) begin
         ram_wr_data.led     = base.led;
         ram_wr_data.level   = fres.level;
         ram_wr_data.falling = fres.falling;
      end else begin
         ram_wr_data = base;
      end
      // on a stall, re-read the held slot so its data stays on the port
      ram_rd_en   = (state_ff == ST_WALK) &&
                    (mod_stall || (rd_idx_ff < CNT_W'(SLOT_COUNT)));
      ram_rd_addr = mod_stall ? mod_i : rd_idx_ff[SLOT_IDX_W-1:0];
   end

   always_comb begin
      state_in       = state_ff;
      spawn_int_in   = spawn_int_ff;
      upd_int_in     = upd_int_ff;
      limit_in       = limit_ff;
      now_in         = now_ff;
      rnd_in         = rnd_ff;
      active_in      = active_ff;
      count_in       = count_ff;
      last_spawn_in  = last_spawn_ff;
      last_update_in = last_update_ff;
      spawn_in       = spawn_ff;
      upd_in         = upd_ff;
      rd_idx_in      = rd_idx_ff;
      mod_valid_in   = mod_valid_ff;
      mod_idx_in     = mod_idx_ff;
      pend_valid_in  = pend_valid_ff;
      pend_kind_in   = pend_kind_ff;
      pend_led_in    = pend_led_ff;
      pend_red_in    = pend_red_ff;
      pend_green_in  = pend_green_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_led_in     = rsp_led_ff;
      rsp_red_in     = rsp_red_ff;
      rsp_green_in   = rsp_green_ff;
      rsp_last_in    = rsp_last_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         case (csr_index)
            CSR_SPAWN_INTERVAL:  spawn_int_in = csr_wdata;
            CSR_UPDATE_INTERVAL: upd_int_in   = csr_wdata;
            CSR_ACTIVE_LIMIT:    limit_in     = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in   = req_now_ms;
               rnd_in   = req_random_led;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            spawn_in     = (count_ff < limit_ff) && (spawn_age > {16'd0, spawn_int_ff});
            upd_in       = update_age > {16'd0, upd_int_ff};
            rd_idx_in    = '0;
            mod_valid_in = 1'b0;
            if (!spawn_in && !upd_in) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
            if (upd_in) begin
               pend_valid_in = 1'b1;
               pend_kind_in  = KIND_CLEAR;
               pend_led_in   = 8'd0;
               pend_red_in   = 8'd0;
               pend_green_in = 6'd0;
            end
         end
         ST_WALK: begin
            if (!mod_stall) begin
               if (walk_busy && live) begin
                  active_in[mod_i] = !(upd_ff && fres.freed);
                  if (spawn_here) begin
                     spawn_in      = 1'b0;
                     count_in      = count_ff + 1'b1;
                     last_spawn_in = now_ff;
                  end else if (upd_ff && fres.freed) begin
                     count_in = count_ff - 1'b1;
                  end
               end
               if (emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = pend_kind_ff;
                     rsp_led_in   = pend_led_ff;
                     rsp_red_in   = pend_red_ff;
                     rsp_green_in = pend_green_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_kind_in  = KIND_PIXEL;
                  pend_led_in   = base.led;
                  pend_red_in   = fres.level;
                  pend_green_in = fres.green;
               end
               if (rd_idx_ff < CNT_W'(SLOT_COUNT)) begin
                  mod_valid_in = 1'b1;
                  mod_idx_in   = rd_idx_ff;
                  rd_idx_in    = rd_idx_ff + 1'b1;
               end else begin
                  mod_valid_in = 1'b0;
                  if (!mod_valid_ff) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pend_kind_ff;
               rsp_led_in    = pend_led_ff;
               rsp_red_in    = pend_red_ff;
               rsp_green_in  = pend_green_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
            if (upd_ff && (state_in == ST_IDLE)) begin
               last_update_in = now_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         spawn_int_ff   <= 16'd500;
         upd_int_ff     <= 16'd30;
         limit_ff       <= CNT_W'(30);
         active_ff      <= '0;
         count_ff       <= '0;
         last_spawn_ff  <= '0;
         last_update_ff <= '0;
         spawn_ff       <= 1'b0;
         upd_ff         <= 1'b0;
         rd_idx_ff      <= '0;
         mod_valid_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         spawn_int_ff   <= spawn_int_in;
         upd_int_ff     <= upd_int_in;
         limit_ff       <= limit_in;
         active_ff      <= active_in;
         count_ff       <= count_in;
         last_spawn_ff  <= last_spawn_in;
         last_update_ff <= last_update_in;
         spawn_ff       <= spawn_in;
         upd_ff         <= upd_in;
         rd_idx_ff      <= rd_idx_in;
         mod_valid_ff   <= mod_valid_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      now_ff        <= now_in;
      rnd_ff        <= rnd_in;
      mod_idx_ff    <= mod_idx_in;
      pend_kind_ff  <= pend_kind_in;
      pend_led_ff   <= pend_led_in;
      pend_red_ff   <= pend_red_in;
      pend_green_ff <= pend_green_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_led_ff    <= rsp_led_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_led_index = rsp_led_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_last      = rsp_last_ff;

   // active count tracks the active bits
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(active_ff)))
      else $error("active count out of step with active bits");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOT_COUNT))
      else $error("active count above pool size");

   // a stalled modify stage keeps its slot and its held word
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && mod_stall) |=>
         (mod_idx_ff == $past(mod_idx_ff) && mod_valid_ff && pend_valid_ff))
      else $error("modify stage moved during output stall");

endmodule
